// ===== hdl/gfss_pkg.sv =====
// Shared types and constants for the gesture fan and servo sweep controller.
package gfss_pkg;

  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = 40;
  localparam int unsigned CfgAddrBits = 4;
  localparam int unsigned PosBits     = 10;

  typedef logic [PosBits-1:0] pos_t;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegSweepPeriod = 2'd0,
    RegLedHold     = 2'd1,
    RegHorizCenter = 2'd2,
    RegVertCenter  = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    GestFan700C    = 5'd5,
    GestHorizStop  = 5'd6,
    GestVertStop   = 5'd13,
    GestOff        = 5'd14,
    GestFan900     = 5'd15,
    GestVertStart  = 5'd16,
    GestHorizStart = 5'd18,
    GestFan300     = 5'd19,
    GestOnA        = 5'd20,
    GestFan500A    = 5'd21,
    GestFan500B    = 5'd22,
    GestOnB        = 5'd24,
    GestFan700A    = 5'd26,
    GestFan700B    = 5'd27,
    GestFan500C    = 5'd28,
    GestFan500D    = 5'd29,
    GestFan700D    = 5'd30
  } gesture_e;

  localparam pos_t FanOff  = 10'd0;
  localparam pos_t Fan300  = 10'd300;
  localparam pos_t Fan500  = 10'd500;
  localparam pos_t Fan700  = 10'd700;
  localparam pos_t Fan900  = 10'd900;
  localparam pos_t HorizHome = 10'd420;

  localparam logic signed [11:0] HorizUpperLimit = 12'sd700;
  localparam logic signed [11:0] HorizLowerLimit = 12'sd200;
  localparam pos_t               HorizUpperJump  = 10'd698;
  localparam pos_t               HorizLowerJump  = 10'd204;
  localparam logic signed [11:0] VertUpperLimit  = 12'sd800;
  localparam logic signed [11:0] VertUpperFold   = 12'sd1600;
  localparam logic signed [11:0] VertLowerLimit  = 12'sd350;
  localparam logic signed [11:0] VertLowerFold   = 12'sd700;
  localparam logic signed [11:0] SweepStep       = 12'sd2;

  localparam logic [7:0] SweepPeriodReset = 8'd10;
  localparam logic [7:0] LedHoldReset     = 8'd100;
  localparam pos_t       CenterReset      = 10'd750;

endpackage

// ===== hdl/gesture_fan_servo_sweep_control.sv =====
// Gesture fan and two-axis servo sweep controller, top level.
//
// Input stream: s_axis_tuser_i = 1 marks a gesture command, 0 a millisecond
// tick; s_axis_tdata_i[4:0] carries the gesture id (ignored on ticks).
// Output stream: one status word per input request, holding fan duty,
// both servo positions, LED, power and sweep flags.
// Configuration over APB: sweep_period at 0x0, led_hold at 0x4,
// horiz_center at 0x8, vert_center at 0xC; write only while idle.
// The state update and the result word are registered together at the
// accepting edge. Throughput is one request per cycle while the output
// word is taken, set by that single state register stage.
// While the output word waits, s_axis_tready_o stays high only if the word
// is taken in the same cycle; a stalled receiver therefore holds off the
// input after one buffered word.
// Reset: unit off, fan 0, sweeps stopped, both servos at 750, LED off,
// registers at 10, 100, 750, 750, output stream empty.
module gesture_fan_servo_sweep_control #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [4:0] gesture_id, [7:5] zero
  input  logic [gfss_pkg::InDataBits-1:0]     s_axis_tdata_i,
  // [0] mode (1 = gesture, 0 = tick)
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [9:0] fan_duty, [19:10] horiz_position, [29:20] vert_position,
  // [30] led_lit, [31] powered, [32] horiz_sweeping, [33] vert_sweeping,
  // [39:34] zero
  output logic [gfss_pkg::OutDataBits-1:0]    m_axis_tdata_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gfss_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import gfss_pkg::*;

  localparam int unsigned CmpBits = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // configuration
  logic [7:0] sweep_period_q, led_hold_q;
  pos_t       horiz_center_q, vert_center_q;
  reg_e       cfg_idx;
  logic       cfg_wr;

  // unit state
  logic power_q, power_d;
  pos_t fan_q, fan_d;
  logic h_en_q, h_en_d, h_down_q, h_down_d;
  pos_t h_pos_q, h_pos_d;
  logic v_en_q, v_en_d, v_down_q, v_down_d;
  pos_t v_pos_q, v_pos_d;
  cnt_t h_el_q, h_el_d, v_el_q, v_el_d, led_el_q, led_el_d;

  logic                   out_valid_q;
  logic [OutDataBits-1:0] out_data_q, out_data_d;
  logic                   in_acc;
  logic                   led_lit;

  logic                   mode;
  logic [4:0]             gid;
  cnt_t                   h_cnt, v_cnt;
  logic                   h_step, v_step;
  logic signed [11:0]     h_next, v_p0, v_p1, v_p2;

  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      RegSweepPeriod: prdata = {24'd0, sweep_period_q};
      RegLedHold:     prdata = {24'd0, led_hold_q};
      RegHorizCenter: prdata = {22'd0, horiz_center_q};
      RegVertCenter:  prdata = {22'd0, vert_center_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_period_q <= SweepPeriodReset;
      led_hold_q     <= LedHoldReset;
      horiz_center_q <= CenterReset;
      vert_center_q  <= CenterReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegSweepPeriod: sweep_period_q <= pwdata[7:0];
        RegLedHold:     led_hold_q     <= pwdata[7:0];
        RegHorizCenter: horiz_center_q <= pwdata[PosBits-1:0];
        RegVertCenter:  vert_center_q  <= pwdata[PosBits-1:0];
        default: ;
      endcase
    end
  end

  assign mode            = s_axis_tuser_i;
  assign gid             = s_axis_tdata_i[4:0];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // saturating tick counts and period test
  assign h_cnt  = (h_el_q == CntMax) ? CntMax : h_el_q + cnt_t'(1);
  assign v_cnt  = (v_el_q == CntMax) ? CntMax : v_el_q + cnt_t'(1);
  assign h_step = h_en_q && ((CmpBits'(h_cnt) >= CmpBits'(sweep_period_q)) ||
                             (h_cnt == CntMax));
  assign v_step = v_en_q && ((CmpBits'(v_cnt) >= CmpBits'(sweep_period_q)) ||
                             (v_cnt == CntMax));

  // horizontal jumps back inside its window, vertical folds off its limits
  assign h_next = $signed({2'b00, h_pos_q}) + (h_down_q ? -SweepStep : SweepStep);
  assign v_p0   = $signed({2'b00, v_pos_q}) + (v_down_q ? -SweepStep : SweepStep);
  assign v_p1   = (v_p0 > VertUpperLimit) ? VertUpperFold - v_p0 : v_p0;
  assign v_p2   = (v_p1 < VertLowerLimit) ? VertLowerFold - v_p1 : v_p1;

  always_comb begin
    power_d  = power_q;
    fan_d    = fan_q;
    h_en_d   = h_en_q;
    h_down_d = h_down_q;
    h_pos_d  = h_pos_q;
    v_en_d   = v_en_q;
    v_down_d = v_down_q;
    v_pos_d  = v_pos_q;
    h_el_d   = h_el_q;
    v_el_d   = v_el_q;
    led_el_d = led_el_q;
    if (!mode) begin
      h_el_d   = h_cnt;
      v_el_d   = v_cnt;
      led_el_d = (led_el_q == CntMax) ? CntMax : led_el_q + cnt_t'(1);
      if (h_step) begin
        h_el_d = '0;
        if (h_next > HorizUpperLimit) begin
          h_pos_d  = HorizUpperJump;
          h_down_d = 1'b1;
        end else if (h_next < HorizLowerLimit) begin
          h_pos_d  = HorizLowerJump;
          h_down_d = 1'b0;
        end else begin
          h_pos_d = h_next[PosBits-1:0];
        end
      end
      if (v_step) begin
        v_el_d  = '0;
        v_pos_d = v_p2[PosBits-1:0];
        if (v_p1 < VertLowerLimit) begin
          v_down_d = 1'b0;
        end else if (v_p0 > VertUpperLimit) begin
          v_down_d = 1'b1;
        end
      end
    end else begin
      led_el_d = '0;
      unique case (gid) inside
        GestOnA, GestOnB: begin
          power_d = 1'b1;
          fan_d   = Fan300;
          h_pos_d = HorizHome;
        end
        GestOff: begin
          power_d = 1'b0;
          fan_d   = FanOff;
          h_en_d  = 1'b0;
          h_pos_d = horiz_center_q;
          v_en_d  = 1'b0;
          v_pos_d = vert_center_q;
        end
        default: begin
          if (power_q) begin
            unique case (gid) inside
              GestFan300: fan_d = Fan300;
              GestFan500A, GestFan500B, GestFan500C, GestFan500D: fan_d = Fan500;
              GestFan700A, GestFan700B, GestFan700C, GestFan700D: fan_d = Fan700;
              GestFan900: fan_d = Fan900;
              GestHorizStart: begin
                h_down_d = 1'b0;
                h_en_d   = 1'b1;
              end
              GestHorizStop: begin
                h_en_d  = 1'b0;
                h_pos_d = HorizHome;
              end
              GestVertStart: v_en_d = 1'b1;
              GestVertStop: begin
                v_en_d  = 1'b0;
                v_pos_d = vert_center_q;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // saturated count always reads as LED off
  assign led_lit = (CmpBits'(led_el_d) <= CmpBits'(led_hold_q)) && (led_el_d != CntMax);

  assign out_data_d = {6'd0, v_en_d, h_en_d, power_d, led_lit, v_pos_d, h_pos_d, fan_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q     <= 1'b0;
      fan_q       <= FanOff;
      h_en_q      <= 1'b0;
      h_down_q    <= 1'b0;
      h_pos_q     <= CenterReset;
      v_en_q      <= 1'b0;
      v_down_q    <= 1'b1;
      v_pos_q     <= CenterReset;
      h_el_q      <= '0;
      v_el_q      <= '0;
      led_el_q    <= CntMax;
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      power_q     <= power_d;
      fan_q       <= fan_d;
      h_en_q      <= h_en_d;
      h_down_q    <= h_down_d;
      h_pos_q     <= h_pos_d;
      v_en_q      <= v_en_d;
      v_down_q    <= v_down_d;
      v_pos_q     <= v_pos_d;
      h_el_q      <= h_el_d;
      v_el_q      <= v_el_d;
      led_el_q    <= led_el_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== hdl/gfss_checker.sv =====
// Port-level assertions for the gesture fan and servo sweep controller.
module gfss_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [gfss_pkg::OutDataBits-1:0] m_axis_tdata_o
);
  import gfss_pkg::*;

  logic [PosBits-1:0] fan;
  assign fan = m_axis_tdata_o[PosBits-1:0];

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

  // every accepted request shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted request produced no result");

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output empty");

  // while off, the fan is stopped and both sweeps are idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[31] |->
      fan == FanOff && !m_axis_tdata_o[32] && !m_axis_tdata_o[33])
    else $error("fan or sweep active while powered off");

  // fan duty is one of the five levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> fan == FanOff || fan == Fan300 || fan == Fan500 ||
                        fan == Fan700 || fan == Fan900)
    else $error("fan duty outside its level set");

endmodule

bind gesture_fan_servo_sweep_control gfss_checker u_gfss_checker (.*);

// ===== sim/gesture_fan_servo_sweep_control_tb.sv =====
// Self-checking testbench for the gesture fan and servo sweep controller.
`timescale 1ns / 100ps

module gesture_fan_servo_sweep_control_tb;
  import gfss_pkg::*;

  localparam int unsigned CountBits  = 8;
  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};
  localparam int unsigned StallLimit = 2000;

  localparam logic ModeTick    = 1'b0;
  localparam logic ModeGesture = 1'b1;

  localparam int   HorizTop      = 700;
  localparam int   HorizBottom   = 200;
  localparam pos_t HorizTopJump  = 10'd698;
  localparam pos_t HorizBotJump  = 10'd204;
  localparam pos_t HorizHomePos  = 10'd420;
  localparam int   VertTop       = 800;
  localparam int   VertTopFold   = 1600;
  localparam int   VertBottom    = 350;
  localparam int   VertBotFold   = 700;

  typedef struct packed {
    logic [5:0] pad;
    logic       vert_sweeping;
    logic       horiz_sweeping;
    logic       powered;
    logic       led_lit;
    pos_t       vert_position;
    pos_t       horiz_position;
    pos_t       fan_duty;
  } status_t;

  class sweep_scoreboard;
    logic [7:0] sweep_period;
    logic [7:0] led_hold;
    pos_t horiz_center;
    pos_t vert_center;
    logic power_on;
    pos_t fan_level;
    logic horiz_run;
    logic horiz_dn;
    pos_t horiz_at;
    logic vert_run;
    logic vert_dn;
    pos_t vert_at;
    logic [CountBits-1:0] horiz_ticks;
    logic [CountBits-1:0] vert_ticks;
    logic [CountBits-1:0] led_ticks;
    status_t status_q[$];
    int unsigned errors;

    function new();
      sweep_period = 8'd10;
      led_hold     = 8'd100;
      horiz_center = 10'd750;
      vert_center  = 10'd750;
      power_on     = 1'b0;
      fan_level    = '0;
      horiz_run    = 1'b0;
      horiz_dn     = 1'b0;
      horiz_at     = horiz_center;
      vert_run     = 1'b0;
      vert_dn      = 1'b1;
      vert_at      = vert_center;
      horiz_ticks  = '0;
      vert_ticks   = '0;
      led_ticks    = CntMax;
      errors       = 0;
    endfunction

    function void set_register(reg_e idx, logic [31:0] value);
      case (idx)
        RegSweepPeriod: sweep_period = value[7:0];
        RegLedHold:     led_hold     = value[7:0];
        RegHorizCenter: horiz_center = value[9:0];
        RegVertCenter:  vert_center  = value[9:0];
        default: ;
      endcase
    endfunction

    function logic [CountBits-1:0] count_up(logic [CountBits-1:0] c);
      return (c == CntMax) ? c : c + 1'b1;
    endfunction

    function bit step_due(logic [CountBits-1:0] c);
      return (c >= sweep_period) || (c == CntMax);
    endfunction

    function void step_horiz();
      int nxt;
      nxt = int'(horiz_at) + (horiz_dn ? -2 : 2);
      if (nxt > HorizTop) begin
        horiz_at = HorizTopJump;
        horiz_dn = 1'b1;
      end else if (nxt < HorizBottom) begin
        horiz_at = HorizBotJump;
        horiz_dn = 1'b0;
      end else begin
        horiz_at = pos_t'(nxt);
      end
    endfunction

    function void step_vert();
      int p;
      p = int'(vert_at) + (vert_dn ? -2 : 2);
      // reflect off the top first, then off the bottom
      if (p > VertTop) begin
        p = VertTopFold - p;
        vert_dn = 1'b1;
      end
      if (p < VertBottom) begin
        p = VertBotFold - p;
        vert_dn = 1'b0;
      end
      vert_at = pos_t'(p);
    endfunction

    function void advance_tick();
      horiz_ticks = count_up(horiz_ticks);
      vert_ticks  = count_up(vert_ticks);
      led_ticks   = count_up(led_ticks);
      if (horiz_run && step_due(horiz_ticks)) begin
        step_horiz();
        horiz_ticks = '0;
      end
      if (vert_run && step_due(vert_ticks)) begin
        step_vert();
        vert_ticks = '0;
      end
    endfunction

    function void apply_gesture(logic [4:0] id);
      led_ticks = '0;
      case (id)
        GestOnA, GestOnB: begin
          power_on  = 1'b1;
          fan_level = 10'd300;
          horiz_at  = HorizHomePos;
        end
        GestOff: begin
          power_on  = 1'b0;
          fan_level = 10'd0;
          horiz_run = 1'b0;
          horiz_at  = horiz_center;
          vert_run  = 1'b0;
          vert_at   = vert_center;
        end
        default: begin
          if (power_on) begin
            case (id)
              GestFan300: fan_level = 10'd300;
              GestFan500A, GestFan500B, GestFan500C, GestFan500D: fan_level = 10'd500;
              GestFan700A, GestFan700B, GestFan700C, GestFan700D: fan_level = 10'd700;
              GestFan900: fan_level = 10'd900;
              GestHorizStart: begin
                horiz_dn  = 1'b0;
                horiz_run = 1'b1;
              end
              GestHorizStop: begin
                horiz_run = 1'b0;
                horiz_at  = HorizHomePos;
              end
              GestVertStart: vert_run = 1'b1;
              GestVertStop: begin
                vert_run = 1'b0;
                vert_at  = vert_center;
              end
              default: ;
            endcase
          end
        end
      endcase
    endfunction

    function void note_request(logic mode, logic [4:0] id);
      status_t s;
      if (mode == ModeGesture) apply_gesture(id);
      else advance_tick();
      s                = '0;
      s.fan_duty       = fan_level;
      s.horiz_position = horiz_at;
      s.vert_position  = vert_at;
      s.led_lit        = (led_ticks <= led_hold) && (led_ticks != CntMax);
      s.powered        = power_on;
      s.horiz_sweeping = horiz_run;
      s.vert_sweeping  = vert_run;
      status_q.push_back(s);
    endfunction

    function void match(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataBits-1:0] word);
      status_t got;
      status_t want;
      got = status_t'(word);
      if (status_q.size() == 0) begin
        $error("result with nothing pending: %h", word);
        errors++;
        return;
      end
      want = status_q.pop_front();
      match("fan_duty", want.fan_duty, got.fan_duty);
      match("horiz_position", want.horiz_position, got.horiz_position);
      match("vert_position", want.vert_position, got.vert_position);
      match("led_lit", want.led_lit, got.led_lit);
      match("powered", want.powered, got.powered);
      match("horiz_sweeping", want.horiz_sweeping, got.horiz_sweeping);
      match("vert_sweeping", want.vert_sweeping, got.vert_sweeping);
      match("pad", want.pad, got.pad);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [InDataBits-1:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OutDataBits-1:0] m_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sweep_scoreboard sb = new();
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned quiet_cycles = 0;

  gesture_e fan_codes[10] = '{GestFan300, GestFan500A, GestFan500B, GestFan500C,
                              GestFan500D, GestFan700A, GestFan700B, GestFan700C,
                              GestFan700D, GestFan900};

  gesture_fan_servo_sweep_control #(
    .COUNT_BITS(CountBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic mode, logic [4:0] id);
    int gap;
    gap = (((sent_count / 97) % 4) == 2) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {3'b000, id};
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(mode, id);
    sent_count++;
  endtask

  task automatic take_result();
    int stall;
    stall = (((got_count / 130) % 4) == 1) ? 0 : $urandom_range(0, 6);
    // hold off long enough for the input side to back up
    if (got_count == 700) stall = 150;
    if (stall > 0) begin
      m_ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    m_ready <= 1'b1;
    do @(posedge clk_i); while (!m_valid);
    sb.check_result(m_data);
    got_count++;
  endtask

  task automatic write_register(reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] period, logic [31:0] hold,
                             logic [31:0] h_center, logic [31:0] v_center);
    write_register(RegSweepPeriod, period);
    write_register(RegLedHold, hold);
    write_register(RegHorizCenter, h_center);
    write_register(RegVertCenter, v_center);
  endtask

  // Drop valid and wait until every pending result has drained.
  task automatic settle_idle();
    s_valid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_request(ModeTick, 5'($urandom_range(0, 31)));
  endtask

  task automatic run_bursts(int unsigned budget);
    int unsigned start;
    int unsigned len;
    int unsigned r;
    start = sent_count;
    while (sent_count - start < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        send_request(ModeGesture, $urandom_range(0, 1) ? GestOnA : GestOnB);
        if ($urandom_range(0, 3) != 0) send_request(ModeGesture, GestHorizStart);
        if ($urandom_range(0, 3) != 0) send_request(ModeGesture, GestVertStart);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 450) : $urandom_range(10, 120);
        repeat (len) begin
          // stop the burst once the budget is spent
          if (sent_count - start >= budget) break;
          r = $urandom_range(0, 99);
          if (r < 88) begin
            send_tick();
          end else if (r < 95) begin
            send_request(ModeGesture, fan_codes[$urandom_range(0, 9)]);
          end else if (r < 98) begin
            send_request(ModeGesture, 5'($urandom_range(0, 31)));
          end else begin
            case ($urandom_range(0, 2))
              0: send_request(ModeGesture, GestOff);
              1: send_request(ModeGesture, GestHorizStop);
              default: send_request(ModeGesture, GestVertStop);
            endcase
          end
        end
      end else begin
        repeat ($urandom_range(5, 30)) begin
          if (sent_count - start >= budget) break;
          send_request(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever take_result();
  end

  initial begin
    repeat (13) @(posedge clk_i);

    // directed: ignored ids while off, every command, then power cycle
    send_request(ModeTick, 5'd31);
    send_request(ModeGesture, 5'd0);
    send_request(ModeGesture, GestFan900);
    send_request(ModeGesture, GestHorizStart);
    send_request(ModeGesture, GestOnA);
    foreach (fan_codes[i]) send_request(ModeGesture, fan_codes[i]);
    send_request(ModeGesture, GestHorizStart);
    send_request(ModeGesture, GestVertStart);
    send_request(ModeTick, 5'd0);
    send_request(ModeTick, 5'd31);
    send_request(ModeGesture, GestHorizStop);
    send_request(ModeGesture, GestVertStop);
    send_request(ModeGesture, GestOff);
    send_request(ModeGesture, GestOnB);
    send_request(ModeGesture, 5'd31);
    send_request(ModeGesture, GestOff);
    run_bursts(150);
    settle_idle();

    load_config(1, 20, 750, 750);
    run_bursts(300);
    settle_idle();

    load_config(0, 0, 0, 0);
    run_bursts(300);
    settle_idle();

    load_config(255, 255, 1023, 1023);
    run_bursts(200);
    settle_idle();

    load_config(2, 254, $urandom_range(0, 1023), $urandom_range(0, 1023));
    run_bursts(225);
    settle_idle();

    load_config($urandom_range(0, 12), $urandom_range(0, 255),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
    run_bursts(250);
    settle_idle();

    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gfss_pkg.sv
hdl/gesture_fan_servo_sweep_control.sv
hdl/gfss_checker.sv
sim/gesture_fan_servo_sweep_control_tb.sv
